FILE: rtl/ted_pkg.sv
// shared types and constants for the text encoding detector
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ENC_W  = 3;

  localparam logic [ENC_W-1:0] ENC_UTF8     = 3'd0;
  localparam logic [ENC_W-1:0] ENC_UTF8_BOM = 3'd1;
  localparam logic [ENC_W-1:0] ENC_UTF16_LE = 3'd2;
  localparam logic [ENC_W-1:0] ENC_UTF16_BE = 3'd3;
  localparam logic [ENC_W-1:0] ENC_ANSI     = 3'd4;

  localparam logic [BYTE_W-1:0] BOM8_0  = 8'hEF;
  localparam logic [BYTE_W-1:0] BOM8_1  = 8'hBB;
  localparam logic [BYTE_W-1:0] BOM8_2  = 8'hBF;
  localparam logic [BYTE_W-1:0] BOM16_A = 8'hFF;
  localparam logic [BYTE_W-1:0] BOM16_B = 8'hFE;

  localparam logic [BYTE_W-1:0] MASK_CONT   = 8'd192;
  localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'd224;
  localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'd240;
  localparam logic [BYTE_W-1:0] MASK_LEAD5  = 8'd248;
  localparam logic [BYTE_W-1:0] CONT_MARK   = 8'd128;
  localparam logic [BYTE_W-1:0] LEAD2_MARK  = 8'd192;
  localparam logic [BYTE_W-1:0] LEAD3_MARK  = 8'd224;
  localparam logic [BYTE_W-1:0] LEAD4_MARK  = 8'd240;
  localparam logic [BYTE_W-1:0] LEAD2_MAX_BAD = 8'd193;
  localparam logic [BYTE_W-1:0] LEAD4_LIMIT = 8'd245;

  typedef struct packed {
    logic [1:0]        count;
    logic [BYTE_W-1:0] head0;
    logic [BYTE_W-1:0] head1;
    logic [BYTE_W-1:0] head2;
    logic [1:0]        pend;
    logic              invalid;
    logic              stopped;
  } ted_state_t;

endpackage

`default_nettype wire

FILE: rtl/ted_step.sv
// per-byte state update and end-of-file encoding decision
`timescale 1ns / 1ps
`default_nettype none

module ted_step (
  input  wire ted_pkg::ted_state_t           state,
  input  wire logic [ted_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          has_byte,
  output ted_pkg::ted_state_t                state_nxt,
  output logic [ted_pkg::ENC_W-1:0]          encoding
);
  import ted_pkg::*;

  logic bad;

  // head capture and utf-8 scan
  always_comb begin
    state_nxt = state;
    if (has_byte) begin
      case (state.count)
        2'd0: begin
          state_nxt.head0 = data_byte;
          state_nxt.count = 2'd1;
        end
        2'd1: begin
          state_nxt.head1 = data_byte;
          state_nxt.count = 2'd2;
        end
        2'd2: begin
          state_nxt.head2 = data_byte;
          state_nxt.count = 2'd3;
        end
        default: begin
          state_nxt.count = state.count;
        end
      endcase
      if (!state.stopped && !state.invalid) begin
        if (data_byte == '0) begin
          if (state.pend != 2'd0) begin
            state_nxt.invalid = 1'b1;
          end
          state_nxt.stopped = 1'b1;
        end else if (state.pend != 2'd0) begin
          if ((data_byte & MASK_CONT) != CONT_MARK) begin
            state_nxt.invalid = 1'b1;
          end else begin
            state_nxt.pend = state.pend - 2'd1;
          end
        end else if (data_byte < CONT_MARK) begin
          state_nxt.pend = 2'd0;
        end else if ((data_byte & MASK_LEAD3) == LEAD2_MARK && data_byte > LEAD2_MAX_BAD) begin
          state_nxt.pend = 2'd1;
        end else if ((data_byte & MASK_LEAD4) == LEAD3_MARK) begin
          state_nxt.pend = 2'd2;
        end else if ((data_byte & MASK_LEAD5) == LEAD4_MARK && data_byte < LEAD4_LIMIT) begin
          state_nxt.pend = 2'd3;
        end else begin
          state_nxt.invalid = 1'b1;
        end
      end
    end
  end

  // decision on the state after this beat
  always_comb begin
    bad = state_nxt.invalid || (!state_nxt.stopped && state_nxt.pend != 2'd0);
    if (state_nxt.count == 2'd3 && state_nxt.head0 == BOM8_0 &&
        state_nxt.head1 == BOM8_1 && state_nxt.head2 == BOM8_2) begin
      encoding = ENC_UTF8_BOM;
    end else if (state_nxt.count >= 2'd2 && state_nxt.head0 == BOM16_A &&
                 state_nxt.head1 == BOM16_B) begin
      encoding = ENC_UTF16_LE;
    end else if (state_nxt.count >= 2'd2 && state_nxt.head0 == BOM16_B &&
                 state_nxt.head1 == BOM16_A) begin
      encoding = ENC_UTF16_BE;
    end else if (state_nxt.count < 2'd2) begin
      encoding = ENC_UTF8;
    end else if (state_nxt.head0 == '0) begin
      encoding = ENC_UTF16_BE;
    end else if (state_nxt.head1 == '0) begin
      encoding = ENC_UTF16_LE;
    end else if (bad) begin
      encoding = ENC_ANSI;
    end else begin
      encoding = ENC_UTF8;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_encoding_detector.sv
// top level of the text encoding detector: input register, file state, result register
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_data_byte, in_has_byte, in_last_byte
//   out_     output     out_valid / out_stall out_encoding
//
// one beat per cycle while in_stall is low; a beat is held in the input register and
// the result of a last beat is registered in the result register and shows on out_
// the input register drains every cycle except when it holds a last beat and
// the result register is full and stalled
// reset clears the file state and both valid flags; state clears after each file
`timescale 1ns / 1ps
`default_nettype none

module text_encoding_detector (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ted_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic                         in_has_byte,
  input  wire logic                         in_last_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ted_pkg::ENC_W-1:0]         out_encoding
);
  import ted_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_has_r;
  logic              s1_last_r;
  ted_state_t        state_r;
  ted_state_t        state_nxt;
  logic [ENC_W-1:0]  enc_nxt;
  logic              out_valid_r;
  logic [ENC_W-1:0]  out_encoding_r;
  logic              advance;

  ted_step u_step (
    .state     (state_r),
    .data_byte (s1_byte_r),
    .has_byte  (s1_has_r),
    .state_nxt (state_nxt),
    .encoding  (enc_nxt)
  );

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // file state, cleared after the last beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      if (s1_last_r) begin
        state_r <= '0;
      end else begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_encoding_r <= enc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_encoding = out_encoding_r;

endmodule

`default_nettype wire
